@@ rtl/i2cm_pkg.sv @@
// Shared types, codes and reset values for the I2C master bit sequencer.
// No dependencies; every other RTL file imports this package.

package i2cm_pkg;

	localparam int TIMEOUT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'hFFFF;

	// Request codes carried by req_type.
	localparam logic [2:0] REQ_NONE  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_STOP  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	typedef enum logic [20:0] {
		PH_IDLE    = 21'h000001,
		PH_ST_FALL = 21'h000002,
		PH_ST_LOW  = 21'h000004,
		PH_RS_PREP = 21'h000008,
		PH_RS_RISE = 21'h000010,
		PH_RS_WAIT = 21'h000020,
		PH_SP_PREP = 21'h000040,
		PH_SP_RISE = 21'h000080,
		PH_SP_WAIT = 21'h000100,
		PH_SP_CHK  = 21'h000200,
		PH_WR_LO   = 21'h000400,
		PH_WR_HI   = 21'h000800,
		PH_WA_LO   = 21'h001000,
		PH_WA_HI   = 21'h002000,
		PH_WA_END  = 21'h004000,
		PH_RD_LO   = 21'h008000,
		PH_RD_HI   = 21'h010000,
		PH_RD_SMP  = 21'h020000,
		PH_RA_LO   = 21'h040000,
		PH_RA_HI   = 21'h080000,
		PH_RA_END  = 21'h100000
	} phase_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       scl_in;
		logic       sda_in;
	} in_beat_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] read_byte;
	} out_beat_t;

	typedef struct packed {
		phase_t               phase;
		logic [3:0]           bit_index;
		logic [7:0]           shifter;
		logic                 bus_started;
		logic [TIMEOUT_W-1:0] wait_count;
		logic                 ack_wanted;
		logic                 scl_drv;
		logic                 sda_drv;
		logic [7:0]           last_read;
	} seq_state_t;

	localparam seq_state_t STATE_RESET = '{
		phase:       PH_IDLE,
		bit_index:   4'd0,
		shifter:     8'd0,
		bus_started: 1'b0,
		wait_count:  '0,
		ack_wanted:  1'b0,
		scl_drv:     1'b1,
		sda_drv:     1'b1,
		last_read:   8'd0
	};

endpackage

@@ rtl/i2cm_step.sv @@
// Next-state and result logic for one tick of the I2C master bit sequencer.
// Purely combinational; depends on i2cm_pkg.

module i2cm_step import i2cm_pkg::*; (
	input  seq_state_t           cur,
	input  in_beat_t             beat,
	input  logic [TIMEOUT_W-1:0] timeout,
	output seq_state_t           nxt,
	output out_beat_t            res
);

	logic [TIMEOUT_W-1:0] wc_inc;
	logic                 still_wait;

	// The stretch wait goes on while SCL is low and the incremented count is below the timeout.
	assign wc_inc     = cur.wait_count + TIMEOUT_W'(1);
	assign still_wait = !beat.scl_in && (wc_inc < timeout);

	always_comb begin
		phase_t     ph;
		logic [3:0] bi;
		logic       done;
		logic       ok;

		nxt  = cur;
		ph   = cur.phase;
		bi   = 4'd0;
		done = 1'b0;
		ok   = 1'b0;

		// A new command is taken only while idle.
		if (cur.phase == PH_IDLE) begin
			case (beat.req_type)
				REQ_START: ph = cur.bus_started ? PH_RS_PREP : PH_ST_FALL;
				REQ_STOP:  ph = PH_SP_PREP;
				REQ_WRITE: begin
					nxt.shifter   = beat.data_byte;
					nxt.bit_index = 4'd0;
					ph            = PH_WR_LO;
				end
				REQ_READ: begin
					nxt.shifter    = 8'd0;
					nxt.bit_index  = 4'd0;
					nxt.ack_wanted = beat.send_ack;
					ph             = PH_RD_LO;
				end
				default: ;
			endcase
		end

		nxt.phase = ph;

		case (ph)
			PH_IDLE: ;
			PH_ST_FALL: begin
				nxt.sda_drv = 1'b0;
				nxt.scl_drv = 1'b1;
				nxt.phase   = PH_ST_LOW;
			end
			PH_ST_LOW: begin
				nxt.sda_drv     = 1'b0;
				nxt.scl_drv     = 1'b0;
				nxt.bus_started = 1'b1;
				done            = 1'b1;
				ok              = 1'b1;
				nxt.phase       = PH_IDLE;
			end
			PH_RS_PREP: begin
				nxt.sda_drv = 1'b1;
				nxt.scl_drv = 1'b0;
				nxt.phase   = PH_RS_RISE;
			end
			PH_RS_RISE: begin
				nxt.sda_drv    = 1'b1;
				nxt.scl_drv    = 1'b1;
				nxt.wait_count = '0;
				nxt.phase      = PH_RS_WAIT;
			end
			PH_RS_WAIT: begin
				if (!beat.scl_in) begin
					nxt.wait_count = wc_inc;
				end
				if (!still_wait) begin
					if (!beat.sda_in) begin
						done      = 1'b1;
						nxt.phase = PH_IDLE;
					end else begin
						nxt.sda_drv = 1'b0;
						nxt.phase   = PH_ST_LOW;
					end
				end
			end
			PH_SP_PREP: begin
				nxt.sda_drv = 1'b0;
				nxt.scl_drv = 1'b0;
				nxt.phase   = PH_SP_RISE;
			end
			PH_SP_RISE: begin
				nxt.scl_drv    = 1'b1;
				nxt.wait_count = '0;
				nxt.phase      = PH_SP_WAIT;
			end
			PH_SP_WAIT: begin
				if (!beat.scl_in) begin
					nxt.wait_count = wc_inc;
				end
				if (!still_wait) begin
					nxt.sda_drv = 1'b1;
					nxt.phase   = PH_SP_CHK;
				end
			end
			PH_SP_CHK: begin
				done = 1'b1;
				if (beat.sda_in) begin
					ok              = 1'b1;
					nxt.bus_started = 1'b0;
				end
				nxt.phase = PH_IDLE;
			end
			PH_WR_LO: begin
				nxt.scl_drv = 1'b0;
				nxt.sda_drv = nxt.shifter[7];
				nxt.phase   = PH_WR_HI;
			end
			PH_WR_HI: begin
				bi            = nxt.bit_index + 4'd1;
				nxt.scl_drv   = 1'b1;
				nxt.shifter   = {nxt.shifter[6:0], 1'b0};
				nxt.bit_index = bi;
				nxt.phase     = bi[3] ? PH_WA_LO : PH_WR_LO;
			end
			PH_WA_LO: begin
				nxt.scl_drv = 1'b0;
				nxt.sda_drv = 1'b1;
				nxt.phase   = PH_WA_HI;
			end
			PH_WA_HI: begin
				nxt.scl_drv = 1'b1;
				nxt.phase   = PH_WA_END;
			end
			PH_WA_END: begin
				nxt.scl_drv = 1'b0;
				done        = 1'b1;
				ok          = !beat.sda_in;
				nxt.phase   = PH_IDLE;
			end
			PH_RD_LO: begin
				nxt.scl_drv = 1'b0;
				nxt.sda_drv = 1'b1;
				nxt.phase   = PH_RD_HI;
			end
			PH_RD_HI: begin
				nxt.scl_drv = 1'b1;
				nxt.phase   = PH_RD_SMP;
			end
			PH_RD_SMP: begin
				bi            = nxt.bit_index + 4'd1;
				nxt.shifter   = {nxt.shifter[6:0], beat.sda_in};
				nxt.bit_index = bi;
				nxt.phase     = bi[3] ? PH_RA_LO : PH_RD_LO;
			end
			PH_RA_LO: begin
				nxt.scl_drv = 1'b0;
				nxt.sda_drv = !nxt.ack_wanted;
				nxt.phase   = PH_RA_HI;
			end
			PH_RA_HI: begin
				nxt.scl_drv = 1'b1;
				nxt.phase   = PH_RA_END;
			end
			PH_RA_END: begin
				nxt.scl_drv   = 1'b0;
				nxt.sda_drv   = 1'b1;
				nxt.last_read = nxt.shifter;
				done          = 1'b1;
				ok            = 1'b1;
				nxt.phase     = PH_IDLE;
			end
			default: nxt.phase = PH_IDLE;
		endcase

		res.scl_release = nxt.scl_drv;
		res.sda_release = nxt.sda_drv;
		res.busy_res    = (nxt.phase != PH_IDLE);
		res.done_res    = done;
		res.success     = ok;
		res.read_byte   = nxt.last_read;
	end

endmodule

@@ rtl/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer: an input beat is registered in stage 1, passes through the
// combinational step logic and is registered in the result register; throughput is one
// beat per cycle while the output is not stalled.
// arst_n clears the sequencer state (idle, both lines released, last read byte zero),
// empties both pipeline registers and sets the stretch timeout to 65535.
// Depends on i2cm_pkg and i2cm_step.

module i2c_master_bit_sequencer import i2cm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_beat_t             in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_beat_t            out_beat,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata
);

	// Stage 1 holds the accepted tick; the step logic turns it into a result and the
	// next sequencer state in one pass. The result register decouples the output
	// handshake, so a new tick can be taken while an older result waits.
	in_beat_t             beat_s1;
	logic                 valid_s1;
	out_beat_t            res_q;
	logic                 res_valid_q;
	seq_state_t           state_q;
	seq_state_t           state_nxt;
	out_beat_t            res_nxt;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 advance;
	logic                 in_acc;

	// The stage-1 beat moves on whenever the result register is empty or being drained.
	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_acc   = in_valid && in_ready;

	assign out_valid = res_valid_q;
	assign out_beat  = res_q;

	i2cm_step u_step (
		.cur     (state_q),
		.beat    (beat_s1),
		.timeout (timeout_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			beat_s1 <= in_beat;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
			timeout_q   <= TIMEOUT_RESET;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			// Sequencer state steps exactly once per processed beat.
			if (advance) begin
				state_q <= state_nxt;
			end
			// Written directly; the user must change it only while idle, unchecked here.
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	// A finished command never leaves the sequencer busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done beat reports busy");

	// Success is only reported together with done.
	a_success_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.success |-> res_q.done_res)
		else $error("success without done");

	// Back-pressure reaches the input only when both registers are full.
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && res_valid_q && !out_ready)
		else $error("input stalled with room in the pipeline");

	// A processed beat always lands in the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed beat lost");

	// The busy flag of a result matches the sequencer state it left behind.
	a_busy_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q.busy_res == (state_q.phase != PH_IDLE)))
		else $error("busy flag disagrees with sequencer state");

endmodule
